// File: rtl/core/assert_macros.svh
// Assertion helpers used by the queue core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/dpq_pkg.sv
package dpq_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 7;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_DEL_MAX = 2'd1,
    MODE_DEL_MIN = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_INSERT  = 3'd1,
    CELL_DEL_MAX = 3'd2,
    CELL_DEL_MIN = 3'd3,
    CELL_CLEAR   = 3'd4
  } cell_op_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic                     valid;
    logic                     gt;
    logic signed [DATA_W-1:0] value;
  } cell_link_t;

endpackage

// File: rtl/core/double_ended_priority_queue_core.sv
// Double-ended priority queue over signed 32-bit values, held sorted in a
// row of shifting cells (minimum in the bottom cell).
// Input channel: in_valid / in_stall with in_mode (insert, delete maximum,
// delete minimum, clear) and in_value (used by insert only).
// Result channel: out_valid / out_stall with out_status, out_is_empty,
// out_max_value, out_min_value and out_occupancy, one result per request,
// describing the queue after that request.
// Every cell updates in the cycle a request is accepted, so a request can be
// accepted in every cycle while the receiver does not stall: throughput is
// one request per cycle. The accepted request waits in a pending register;
// its result is then read from the cell row into the output register, and
// out_valid rises from that output register.
// When the receiver stalls, the output register holds its result and one
// further request is still accepted; in_stall rises only while that request
// waits for the output register.
// Reset (synchronous, rst_n low) empties the queue and drops any pending
// result; the cell contents themselves are not cleared.
`include "assert_macros.svh"

module double_ended_priority_queue_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_mode,
  input  logic [dpq_pkg::DATA_W-1:0]        in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic                              out_is_empty,
  output logic [dpq_pkg::DATA_W-1:0]        out_max_value,
  output logic [dpq_pkg::DATA_W-1:0]        out_min_value,
  output logic [dpq_pkg::OCC_W-1:0]         out_occupancy
);

  localparam int CAP = dpq_pkg::CAPACITY;
  localparam int DW  = dpq_pkg::DATA_W;
  localparam int CW  = dpq_pkg::CNT_W;
  localparam int OW  = dpq_pkg::OCC_W;

  logic [CW-1:0]        count_r, count_nxt;
  logic                 pending_r, pending_nxt;
  dpq_pkg::status_t     status_pend_r, status_nxt;
  dpq_pkg::cell_op_t    cell_op;
  logic                 in_acc, load;

  logic                 out_valid_r, out_valid_nxt;
  dpq_pkg::status_t     out_status_r;
  logic                 out_is_empty_r;
  logic [DW-1:0]        out_max_r, out_min_r;
  logic [OW-1:0]        out_occ_r;

  dpq_pkg::cell_link_t  links [CAP];
  dpq_pkg::cell_link_t  bottom_link, top_link;
  logic [CAP-1:0]       valid_vec;
  logic [CAP-1:0]       top_vec;
  logic [DW-1:0]        max_sel;

  assign load     = pending_r && (!out_valid_r || !out_stall);
  assign in_stall = pending_r && !load;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    cell_op    = dpq_pkg::CELL_HOLD;
    count_nxt  = count_r;
    status_nxt = dpq_pkg::ST_DONE;
    if (in_acc) begin
      unique case (dpq_pkg::mode_t'(in_mode))
        dpq_pkg::MODE_INSERT: begin
          if (count_r == CW'(CAP)) begin
            status_nxt = dpq_pkg::ST_FULL;
          end else begin
            cell_op   = dpq_pkg::CELL_INSERT;
            count_nxt = count_r + CW'(1);
          end
        end
        dpq_pkg::MODE_DEL_MAX: begin
          if (count_r == '0) begin
            status_nxt = dpq_pkg::ST_EMPTY;
          end else begin
            cell_op   = dpq_pkg::CELL_DEL_MAX;
            count_nxt = count_r - CW'(1);
          end
        end
        dpq_pkg::MODE_DEL_MIN: begin
          if (count_r == '0) begin
            status_nxt = dpq_pkg::ST_EMPTY;
          end else begin
            cell_op   = dpq_pkg::CELL_DEL_MIN;
            count_nxt = count_r - CW'(1);
          end
        end
        dpq_pkg::MODE_CLEAR: begin
          cell_op   = dpq_pkg::CELL_CLEAR;
          count_nxt = '0;
        end
        default: begin
          cell_op = dpq_pkg::CELL_HOLD;
        end
      endcase
    end
  end

  // The bottom cell sees an occupied neighbor below that never shifts up;
  // the top cell sees an empty neighbor above.
  assign bottom_link = '{valid: 1'b1, gt: 1'b0, value: '0};
  assign top_link    = '{valid: 1'b0, gt: 1'b0, value: '0};

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    dpq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (cell_op),
      .key     ($signed(in_value)),
      .from_lo ((i == 0) ? bottom_link : links[(i == 0) ? 0 : i - 1]),
      .from_hi ((i == CAP - 1) ? top_link : links[(i == CAP - 1) ? i : i + 1]),
      .link    (links[i])
    );
    assign valid_vec[i] = links[i].valid;
    if (i == CAP - 1) begin : g_top
      assign top_vec[i] = links[i].valid;
    end else begin : g_mid
      assign top_vec[i] = links[i].valid && !links[i + 1].valid;
    end
  end

  // At most one cell is the highest occupied one; pick it with an AND-OR.
  always_comb begin
    max_sel = '0;
    for (int i = 0; i < CAP; i++) begin
      max_sel = max_sel | ({DW{top_vec[i]}} & links[i].value);
    end
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);
  assign pending_nxt   = in_acc || (pending_r && !load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      status_pend_r <= status_nxt;
    end
    if (load) begin
      out_status_r   <= status_pend_r;
      out_is_empty_r <= (count_r == '0);
      out_max_r      <= (count_r == '0) ? '0 : max_sel;
      out_min_r      <= (count_r == '0) ? '0 : links[0].value;
      out_occ_r      <= OW'(count_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_is_empty  = out_is_empty_r;
  assign out_max_value = out_max_r;
  assign out_min_value = out_min_r;
  assign out_occupancy = out_occ_r;

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CW'(CAP))
  `ASSERT_ALWAYS(a_cells_match_count, clk, rst_n, $countones(valid_vec) == int'(count_r))
  `ASSERT_ALWAYS(a_top_onehot, clk, rst_n, $onehot0(top_vec))
  `ASSERT_NEXT(a_accept_pends, clk, rst_n, in_acc, pending_r)

endmodule

// File: rtl/core/dpq_cell.sv
module dpq_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dpq_pkg::cell_op_t                op,
  input  logic signed [dpq_pkg::DATA_W-1:0] key,
  input  dpq_pkg::cell_link_t              from_lo,
  input  dpq_pkg::cell_link_t              from_hi,
  output dpq_pkg::cell_link_t              link
);

  logic                              valid_r, valid_nxt;
  logic signed [dpq_pkg::DATA_W-1:0] value_r, value_nxt;
  logic                              gt;

  // Entries are sorted ascending, so the cells holding values above the key
  // form a contiguous run at the top of the occupied region.
  assign gt = valid_r && (value_r > key);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    unique case (op)
      dpq_pkg::CELL_INSERT: begin
        valid_nxt = valid_r || from_lo.valid;
        if (from_lo.gt) begin
          value_nxt = from_lo.value;
        end else if (gt || !valid_r) begin
          value_nxt = key;
        end
      end
      dpq_pkg::CELL_DEL_MAX: begin
        valid_nxt = valid_r && from_hi.valid;
      end
      dpq_pkg::CELL_DEL_MIN: begin
        valid_nxt = from_hi.valid;
        value_nxt = from_hi.value;
      end
      dpq_pkg::CELL_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
  end

  assign link.valid = valid_r;
  assign link.gt    = gt;
  assign link.value = value_r;

endmodule
